### rtl/csp_pkg.sv
// Shared types, sizes and codes for the call stack profiler.
`timescale 1ns / 1ps

package csp_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int NUM_FUNCS   = 256;
  localparam int TIME_BITS   = 48;

  localparam int SA_W  = $clog2(STACK_DEPTH);     // frame memory address
  localparam int SP_W  = $clog2(STACK_DEPTH + 1); // stack pointer, holds the depth itself
  localparam int FN_W  = $clog2(NUM_FUNCS);       // function index
  localparam int OVF_W = 16;
  localparam int SUM_W = 64;
  localparam int CNT_W = 32;

  localparam logic [2:0] CMD_ENTER = 3'd0;
  localparam logic [2:0] CMD_LEAVE = 3'd1;
  localparam logic [2:0] CMD_DROP  = 3'd2;
  localparam logic [2:0] CMD_CLEAR = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_IGNORE = 2'd1;
  localparam logic [1:0] ST_OVFL   = 2'd2;
  localparam logic [1:0] ST_ABSORB = 2'd3;

  typedef struct packed {
    logic [FN_W-1:0]      func;
    logic [TIME_BITS-1:0] enter;
    logic [TIME_BITS-1:0] child;
  } frame_t;

  typedef struct packed {
    logic [SUM_W-1:0]     total;
    logic [SUM_W-1:0]     self_sum;
    logic [CNT_W-1:0]     count;
    logic [TIME_BITS-1:0] longest;
  } stat_t;

  localparam int FRAME_W = $bits(frame_t);
  localparam int STAT_W  = $bits(stat_t);

  typedef enum logic [3:0] {
    OP_PUSH,
    OP_FULL,
    OP_IGN_FN,
    OP_IGN,
    OP_ABSORB,
    OP_POP,
    OP_DROP,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_FRAME,
    FSM_STAT,
    FSM_DONE
  } fsm_t;

endpackage

### rtl/csp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module csp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/call_stack_profiler.sv
// Top level of the call stack profiler: frame stack, statistics table, control.
`timescale 1ns / 1ps

//  channel  direction  handshake                 payload
//  in       input      in_valid / in_ready       in_cmd, in_func_id, in_timestamp
//  out      output     out_valid / out_ready     out_status .. out_depth_now (9 fields)
//  cfg      input      cfg_valid / cfg_ready     cfg_enable
//
//  A leave that pops a frame and a read step through frame memory read,
//  statistics memory read and write back, then return to idle. All other
//  beats go from accept straight to write back. In both cases the result
//  registers as write back completes.
//  One beat is in flight at a time; the frame and statistics memories set the pace.
//  Reset is synchronous; the statistics table clears at once through per-entry
//  valid bits, so there is no clearing pass. cfg_ready is always high.
//  A finished result waits in the output register; the block stalls in write
//  back only when a second result is ready before the first was taken.

module call_stack_profiler (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_func_id,
  input  logic [47:0] in_timestamp,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_result_func,
  output logic [47:0] out_call_ticks,
  output logic [47:0] out_call_self_ticks,
  output logic [63:0] out_sum_total_ticks,
  output logic [63:0] out_sum_self_ticks,
  output logic [31:0] out_calls,
  output logic [47:0] out_longest_ticks,
  output logic [6:0]  out_depth_now,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_enable
);

  localparam logic [csp_pkg::SP_W-1:0] SP_FULL  = csp_pkg::SP_W'(csp_pkg::STACK_DEPTH);
  localparam logic [csp_pkg::SP_W-1:0] SP_ONE   = csp_pkg::SP_W'(1);
  localparam logic [csp_pkg::SP_W-1:0] SP_TWO   = csp_pkg::SP_W'(2);
  localparam logic [csp_pkg::OVF_W-1:0] OVF_MAX = '1;

  // ---------------------------------------------------------------- state
  csp_pkg::fsm_t state_r, state_nxt;
  csp_pkg::op_t  op_r, op_nxt;

  logic                              enable_r;
  logic [csp_pkg::SP_W-1:0]          sp_r, sp_nxt;
  logic [csp_pkg::OVF_W-1:0]         ovf_r, ovf_nxt;
  logic [csp_pkg::NUM_FUNCS-1:0]     stat_vld_r;

  // latched beat
  logic [csp_pkg::FN_W-1:0]          fid_r;
  logic [csp_pkg::TIME_BITS-1:0]     now_r;

  // leave and read pipeline
  logic [csp_pkg::FN_W-1:0]          func_r;
  logic [csp_pkg::TIME_BITS-1:0]     total_r;
  logic [csp_pkg::TIME_BITS-1:0]     child_r;
  logic [csp_pkg::TIME_BITS-1:0]     self_r;
  logic [csp_pkg::TIME_BITS-1:0]     pchild_r;
  csp_pkg::frame_t                   parent_r;
  csp_pkg::stat_t                    st_r;
  logic                              stat_vq_r;

  // output register
  logic                              out_valid_r;
  logic [1:0]                        out_status_r,  status_nxt;
  logic [csp_pkg::FN_W-1:0]          out_func_r,    func_nxt;
  logic [csp_pkg::TIME_BITS-1:0]     out_call_r,    call_nxt;
  logic [csp_pkg::TIME_BITS-1:0]     out_cself_r,   cself_nxt;
  csp_pkg::stat_t                    out_stat_r,    ostat_nxt;
  logic [csp_pkg::SP_W-1:0]          out_depth_r;

  // memories
  logic                              frame_we;
  logic [csp_pkg::SA_W-1:0]          frame_waddr;
  csp_pkg::frame_t                   frame_wdata;
  logic [csp_pkg::SA_W-1:0]          top_raddr, par_raddr;
  logic [csp_pkg::FRAME_W-1:0]       top_rbits, par_rbits;
  csp_pkg::frame_t                   top_frame, par_frame;

  logic                              stat_we;
  logic [csp_pkg::FN_W-1:0]          stat_raddr;
  logic [csp_pkg::STAT_W-1:0]        stat_rbits;
  csp_pkg::stat_t                    stat_new;

  logic in_fire, done_fire;
  logic [csp_pkg::SP_W-1:0]          sp_m1, sp_m2;
  logic [csp_pkg::TIME_BITS:0]       pchild_sum;

  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign sp_m1     = sp_r - SP_ONE;
  assign sp_m2     = sp_r - SP_TWO;

  // ---------------------------------------------------------------- decode
  always_comb begin
    op_nxt = csp_pkg::OP_IGN;
    unique case (in_cmd)
      csp_pkg::CMD_ENTER: begin
        if (!enable_r)            op_nxt = csp_pkg::OP_IGN_FN;
        else if (sp_r == SP_FULL) op_nxt = csp_pkg::OP_FULL;
        else                      op_nxt = csp_pkg::OP_PUSH;
      end
      csp_pkg::CMD_LEAVE: begin
        if (!enable_r)            op_nxt = csp_pkg::OP_IGN;
        else if (ovf_r != '0)     op_nxt = csp_pkg::OP_ABSORB;
        else if (sp_r == '0)      op_nxt = csp_pkg::OP_IGN;
        else                      op_nxt = csp_pkg::OP_POP;
      end
      csp_pkg::CMD_DROP:  op_nxt = csp_pkg::OP_DROP;
      csp_pkg::CMD_CLEAR: op_nxt = csp_pkg::OP_CLEAR;
      csp_pkg::CMD_READ:  op_nxt = csp_pkg::OP_READ;
      default:            op_nxt = csp_pkg::OP_IGN;
    endcase
  end

  // ---------------------------------------------------------------- FSM next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      csp_pkg::FSM_IDLE: begin
        if (in_fire) begin
          state_nxt = (op_nxt == csp_pkg::OP_POP || op_nxt == csp_pkg::OP_READ) ?
                      csp_pkg::FSM_FRAME : csp_pkg::FSM_DONE;
        end
      end
      csp_pkg::FSM_FRAME: state_nxt = csp_pkg::FSM_STAT;
      csp_pkg::FSM_STAT:  state_nxt = csp_pkg::FSM_DONE;
      csp_pkg::FSM_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = csp_pkg::FSM_IDLE;
      end
      default: state_nxt = csp_pkg::FSM_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- FSM outputs
  always_comb begin
    in_ready  = 1'b0;
    done_fire = 1'b0;
    frame_we  = 1'b0;
    stat_we   = 1'b0;
    unique case (state_r)
      csp_pkg::FSM_IDLE: in_ready = 1'b1;
      csp_pkg::FSM_DONE: begin
        done_fire = !out_valid_r || out_ready;
        frame_we  = done_fire && (op_r == csp_pkg::OP_PUSH ||
                                  (op_r == csp_pkg::OP_POP && sp_r >= SP_TWO));
        stat_we   = done_fire && op_r == csp_pkg::OP_POP;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- memories
  // Frame reads for the top and its parent are issued every idle cycle, so the
  // data sits ready the cycle after accept. Two copies give two read ports.
  assign top_raddr = sp_m1[csp_pkg::SA_W-1:0];
  assign par_raddr = sp_m2[csp_pkg::SA_W-1:0];
  assign top_frame = csp_pkg::frame_t'(top_rbits);
  assign par_frame = csp_pkg::frame_t'(par_rbits);

  always_comb begin
    if (op_r == csp_pkg::OP_PUSH) begin
      frame_waddr       = sp_r[csp_pkg::SA_W-1:0];
      frame_wdata.func  = fid_r;
      frame_wdata.enter = now_r;
      frame_wdata.child = '0;
    end else begin
      // pop: fold the call time into the parent's child time
      frame_waddr       = sp_m2[csp_pkg::SA_W-1:0];
      frame_wdata.func  = parent_r.func;
      frame_wdata.enter = parent_r.enter;
      frame_wdata.child = pchild_r;
    end
  end

  csp_ram #(.WIDTH(csp_pkg::FRAME_W), .DEPTH(csp_pkg::STACK_DEPTH)) u_frame_top (
    .clk   (clk),
    .we    (frame_we),
    .waddr (frame_waddr),
    .wdata (frame_wdata),
    .raddr (top_raddr),
    .rdata (top_rbits)
  );

  csp_ram #(.WIDTH(csp_pkg::FRAME_W), .DEPTH(csp_pkg::STACK_DEPTH)) u_frame_par (
    .clk   (clk),
    .we    (frame_we),
    .waddr (frame_waddr),
    .wdata (frame_wdata),
    .raddr (par_raddr),
    .rdata (par_rbits)
  );

  assign stat_raddr = (op_r == csp_pkg::OP_POP) ? top_frame.func : fid_r;

  csp_ram #(.WIDTH(csp_pkg::STAT_W), .DEPTH(csp_pkg::NUM_FUNCS)) u_stat (
    .clk   (clk),
    .we    (stat_we),
    .waddr (func_r),
    .wdata (stat_new),
    .raddr (stat_raddr),
    .rdata (stat_rbits)
  );

  // ---------------------------------------------------------------- datapath
  assign pchild_sum = {1'b0, parent_r.child} + {1'b0, total_r};

  always_comb begin
    stat_new.total    = st_r.total + csp_pkg::SUM_W'(total_r);
    stat_new.self_sum = st_r.self_sum + csp_pkg::SUM_W'(self_r);
    stat_new.count    = (st_r.count == '1) ? st_r.count : st_r.count + csp_pkg::CNT_W'(1);
    stat_new.longest  = (total_r > st_r.longest) ? total_r : st_r.longest;
  end

  // result and stack/overflow updates of the beat in write back
  always_comb begin
    status_nxt = csp_pkg::ST_OK;
    func_nxt   = '0;
    call_nxt   = '0;
    cself_nxt  = '0;
    ostat_nxt  = '0;
    sp_nxt     = sp_r;
    ovf_nxt    = ovf_r;
    case (op_r)
      csp_pkg::OP_PUSH: begin
        func_nxt = fid_r;
        sp_nxt   = sp_r + SP_ONE;
      end
      csp_pkg::OP_FULL: begin
        status_nxt = csp_pkg::ST_OVFL;
        func_nxt   = fid_r;
        ovf_nxt    = (ovf_r == OVF_MAX) ? ovf_r : ovf_r + csp_pkg::OVF_W'(1);
      end
      csp_pkg::OP_IGN_FN: begin
        status_nxt = csp_pkg::ST_IGNORE;
        func_nxt   = fid_r;
      end
      csp_pkg::OP_ABSORB: begin
        status_nxt = csp_pkg::ST_ABSORB;
        ovf_nxt    = ovf_r - csp_pkg::OVF_W'(1);
      end
      csp_pkg::OP_POP: begin
        func_nxt  = func_r;
        call_nxt  = total_r;
        cself_nxt = self_r;
        ostat_nxt = stat_new;
        sp_nxt    = sp_m1;
      end
      csp_pkg::OP_DROP, csp_pkg::OP_CLEAR: begin
        sp_nxt  = '0;
        ovf_nxt = '0;
      end
      csp_pkg::OP_READ: begin
        func_nxt  = fid_r;
        ostat_nxt = st_r;
      end
      default: status_nxt = csp_pkg::ST_IGNORE;
    endcase
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csp_pkg::FSM_IDLE;
      op_r        <= csp_pkg::OP_IGN;
      enable_r    <= 1'b1;
      sp_r        <= '0;
      ovf_r       <= '0;
      stat_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        op_r <= op_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        enable_r <= cfg_enable;
      end
      if (done_fire) begin
        sp_r  <= sp_nxt;
        ovf_r <= ovf_nxt;
        if (op_r == csp_pkg::OP_CLEAR) begin
          stat_vld_r <= '0;
        end else if (op_r == csp_pkg::OP_POP) begin
          stat_vld_r[func_r] <= 1'b1;
        end
      end
      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      fid_r <= in_func_id;
      now_r <= in_timestamp;
    end
    if (state_r == csp_pkg::FSM_FRAME) begin
      func_r    <= stat_raddr;
      total_r   <= now_r - top_frame.enter;
      child_r   <= top_frame.child;
      parent_r  <= par_frame;
      stat_vq_r <= stat_vld_r[stat_raddr];
    end
    if (state_r == csp_pkg::FSM_STAT) begin
      // an entry not written since reset or clear reads as zero
      st_r     <= stat_vq_r ? csp_pkg::stat_t'(stat_rbits) : '0;
      self_r   <= (child_r > total_r) ? '0 : total_r - child_r;
      pchild_r <= pchild_sum[csp_pkg::TIME_BITS] ? '1 :
                  pchild_sum[csp_pkg::TIME_BITS-1:0];
    end
    if (done_fire) begin
      out_status_r <= status_nxt;
      out_func_r   <= func_nxt;
      out_call_r   <= call_nxt;
      out_cself_r  <= cself_nxt;
      out_stat_r   <= ostat_nxt;
      out_depth_r  <= sp_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_result_func     = out_func_r;
  assign out_call_ticks      = out_call_r;
  assign out_call_self_ticks = out_cself_r;
  assign out_sum_total_ticks = out_stat_r.total;
  assign out_sum_self_ticks  = out_stat_r.self_sum;
  assign out_calls           = out_stat_r.count;
  assign out_longest_ticks   = out_stat_r.longest;
  assign out_depth_now       = out_depth_r;

  // ---------------------------------------------------------------- assertions
  // pending overflow drops only build up on a full stack
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (ovf_r != '0) |-> (sp_r == SP_FULL))
    else $error("overflow count pending while stack not full");

  // depth moves only when a beat completes write back
  a_sp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !done_fire |=> $stable(sp_r))
    else $error("stack pointer changed outside write back");

  // a pop never reaches write back on an empty stack
  a_pop_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == csp_pkg::FSM_DONE && op_r == csp_pkg::OP_POP) |-> (sp_r != '0))
    else $error("pop with empty stack");

  // write back returns to idle and leaves a result in the output register
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_fire |=> (state_r == csp_pkg::FSM_IDLE && out_valid_r))
    else $error("write back did not complete");

endmodule
